// ===== rtl/core/uvs_pkg.sv =====
// shared types, constants and helpers for the uv sphere vertex generator
`timescale 1ns / 1ps
package uvs_pkg;

    localparam int IDX_W   = 8;
    localparam int ANG_W   = 32;
    localparam int CORD_W  = 34;
    localparam int MAX_ITER = 24;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // register addresses (byte address / 4)
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] stack_index;
        logic [IDX_W-1:0] slice_index;
    } t_vtx_req;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic               bad_index;
    } t_vtx_res;

    // per-vertex control that rides along the pipeline
    typedef struct packed {
        logic        bad;
        logic        top;
        logic        bottom;
        logic [14:0] radius;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
    } t_vtx_ctl;

    // arctangent table in binary turns
    function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/uvs_div.sv =====
// pipelined restoring divider: quotient of a numerator by a narrow divisor
`timescale 1ns / 1ps
module uvs_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 10,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);
    // one quotient bit per stage
    logic             r_vld [NUM_W+1];
    logic [NUM_W-1:0] r_num [NUM_W+1];
    logic [DEN_W:0]   r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_den [NUM_W+1];
    logic [TAG_W-1:0] r_tag [NUM_W+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0] n_trial;
        logic           n_ge;
        always_comb begin
            n_trial = {r_rem[s][DEN_W-1:0], r_num[s][NUM_W-1]};
            n_ge    = n_trial >= {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1] <= n_ge ? (n_trial - {1'b0, r_den[s]}) : n_trial;
            r_num[s+1] <= {r_num[s][NUM_W-2:0], n_ge};
            r_den[s+1] <= r_den[s];
            r_tag[s+1] <= r_tag[s];
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_num[NUM_W];
    assign o_tag   = r_tag[NUM_W];
endmodule

// ===== rtl/core/uvs_cordic.sv =====
// pipelined rotation cordic giving cosine and sine in q1.30
`timescale 1ns / 1ps
module uvs_cordic #(
    parameter int ITERS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [uvs_pkg::ANG_W-1:0]      i_ang,
    output logic                           o_valid,
    output logic signed [uvs_pkg::CORD_W-1:0] o_cos,
    output logic signed [uvs_pkg::CORD_W-1:0] o_sin
);
    import uvs_pkg::*;

    logic                     r_vld  [ITERS+1];
    logic signed [CORD_W-1:0] r_x    [ITERS+1];
    logic signed [CORD_W-1:0] r_y    [ITERS+1];
    logic signed [ANG_W:0]    r_z    [ITERS+1];
    logic                     r_flip [ITERS+1];
    logic [ANG_W-1:0]         n_ang;
    logic                     n_flip;

    // fold left half plane by half a turn
    always_comb begin
        n_flip = (i_ang + 32'h40000000) >= 32'h80000000;
        n_ang  = n_flip ? i_ang - 32'h80000000 : i_ang;
        r_vld[0]  = i_valid;
        r_x[0]    = CORDIC_GAIN;
        r_y[0]    = '0;
        r_z[0]    = {n_ang[ANG_W-1], n_ang};
        r_flip[0] = n_flip;
    end

    for (genvar s = 0; s < ITERS; s++) begin : g_iter
        logic signed [CORD_W-1:0] n_dx;
        logic signed [CORD_W-1:0] n_dy;
        logic signed [ANG_W:0]    n_a;
        always_comb begin
            n_dx = r_y[s] >>> s;
            n_dy = r_x[s] >>> s;
            n_a  = {1'b0, atan_turn(5'(s))};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            if (!r_z[s][ANG_W]) begin
                r_x[s+1] <= r_x[s] - n_dx;
                r_y[s+1] <= r_y[s] + n_dy;
                r_z[s+1] <= r_z[s] - n_a;
            end else begin
                r_x[s+1] <= r_x[s] + n_dx;
                r_y[s+1] <= r_y[s] - n_dy;
                r_z[s+1] <= r_z[s] + n_a;
            end
            r_flip[s+1] <= r_flip[s];
        end
    end

    assign o_valid = r_vld[ITERS];
    assign o_cos   = r_flip[ITERS] ? -r_x[ITERS] : r_x[ITERS];
    assign o_sin   = r_flip[ITERS] ? -r_y[ITERS] : r_y[ITERS];
endmodule

// ===== rtl/core/uvs_shade.sv =====
// products, rounding and saturation stages building the vertex result
`timescale 1ns / 1ps
module uvs_shade (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  uvs_pkg::t_vtx_ctl                    i_ctl,
    input  logic signed [uvs_pkg::CORD_W-1:0]    i_cp,
    input  logic signed [uvs_pkg::CORD_W-1:0]    i_sp,
    input  logic signed [uvs_pkg::CORD_W-1:0]    i_ct,
    input  logic signed [uvs_pkg::CORD_W-1:0]    i_st,
    output logic                                 o_valid,
    output uvs_pkg::t_vtx_res                    o_res
);
    import uvs_pkg::*;

    // stage a: sin(phi) products and cos(phi) terms
    logic                     r_va;
    t_vtx_ctl                 r_ca;
    logic signed [67:0]       r_pxc;
    logic signed [67:0]       r_pzc;
    logic signed [CORD_W-1:0] r_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else          r_va <= i_valid;
        r_ca  <= i_ctl;
        r_pxc <= i_sp * i_ct;
        r_pzc <= i_sp * i_st;
        r_cp  <= i_cp;
    end

    // stage b: round to q.30 and normals, cos(phi) times radius
    logic                     r_vb;
    t_vtx_ctl                 r_cb;
    logic signed [37:0]       r_qx;
    logic signed [37:0]       r_qz;
    logic signed [15:0]       r_nx;
    logic signed [15:0]       r_ny;
    logic signed [15:0]       r_nz;
    logic signed [49:0]       r_py;
    logic signed [67:0]       n_rx;
    logic signed [67:0]       n_rz;
    logic signed [67:0]       n_nx;
    logic signed [67:0]       n_nz;
    logic signed [CORD_W-1:0] n_ny;

    function automatic logic signed [15:0] clamp_n(input logic signed [67:0] v);
        if (v < -68'sd16384)     return -16'sd16384;
        else if (v > 68'sd16384) return 16'sd16384;
        else                     return v[15:0];
    endfunction

    always_comb begin
        n_rx = (r_pxc + (68'sd1 <<< 29)) >>> 30;
        n_rz = (r_pzc + (68'sd1 <<< 29)) >>> 30;
        n_nx = (r_pxc + (68'sd1 <<< 45)) >>> 46;
        n_nz = (r_pzc + (68'sd1 <<< 45)) >>> 46;
        n_ny = (r_cp + (34'sd1 <<< 15)) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else          r_vb <= r_va;
        r_cb <= r_ca;
        r_qx <= n_rx[37:0];
        r_qz <= n_rz[37:0];
        r_nx <= clamp_n(n_nx);
        r_nz <= clamp_n(n_nz);
        r_ny <= clamp_n(68'(n_ny));
        r_py <= r_cp * $signed({1'b0, r_ca.radius});
    end

    // stage c: scale by radius
    logic               r_vc;
    t_vtx_ctl           r_cc;
    logic signed [53:0] r_px;
    logic signed [53:0] r_pz;
    logic signed [49:0] r_pyc;
    logic signed [15:0] r_nxc;
    logic signed [15:0] r_nyc;
    logic signed [15:0] r_nzc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else          r_vc <= r_vb;
        r_cc  <= r_cb;
        r_px  <= r_qx * $signed({1'b0, r_cb.radius});
        r_pz  <= r_qz * $signed({1'b0, r_cb.radius});
        r_pyc <= r_py;
        r_nxc <= r_nx;
        r_nyc <= r_ny;
        r_nzc <= r_nz;
    end

    // stage d: round, saturate and pick pole or error results
    function automatic logic signed [15:0] sat_q(input logic signed [54:0] v);
        if (v < -55'sd32768)     return -16'sd32768;
        else if (v > 55'sd32767) return 16'sd32767;
        else                     return v[15:0];
    endfunction

    logic               r_vd;
    t_vtx_res           r_res;
    logic signed [54:0] n_x;
    logic signed [54:0] n_z;
    logic signed [54:0] n_y;
    t_vtx_res           n_res;

    always_comb begin
        n_x = (55'(r_px) + (55'sd1 <<< 29)) >>> 30;
        n_z = (55'(r_pz) + (55'sd1 <<< 29)) >>> 30;
        n_y = (55'(r_pyc) + (55'sd1 <<< 29)) >>> 30;
        n_res = '0;
        if (r_cc.bad) begin
            n_res.bad_index = 1'b1;
        end else if (r_cc.top || r_cc.bottom) begin
            n_res.pos_y  = r_cc.top ? $signed({1'b0, r_cc.radius})
                                    : -$signed({1'b0, r_cc.radius});
            n_res.norm_y = r_cc.top ? 16'sd16384 : -16'sd16384;
            n_res.tan_x  = 16'sd256;
            n_res.tex_v  = r_cc.top ? 16'd0 : 16'd32768;
        end else begin
            n_res.pos_x  = sat_q(n_x);
            n_res.pos_y  = sat_q(n_y);
            n_res.pos_z  = sat_q(n_z);
            n_res.norm_x = r_nxc;
            n_res.norm_y = r_nyc;
            n_res.norm_z = r_nzc;
            n_res.tan_x  = sat_q(-n_z);
            n_res.tan_z  = sat_q(n_x);
            n_res.tex_u  = r_cc.tex_u;
            n_res.tex_v  = r_cc.tex_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else          r_vd <= r_vc;
        r_res <= n_res;
    end

    assign o_valid = r_vd;
    assign o_res   = r_res;
endmodule

// ===== rtl/core/uv_sphere_vertex_generator.sv =====
// top level: config registers, angle dividers, cordics and result stages
// pipeline: INDEX_BITS+34 divider stages, a collect register, the cordic stages and the result stages
// throughput: one vertex per clock, busy is always low
// rate is set by the bit-per-stage divider and cordic pipelines
// synchronous active-low reset clears valid bits and loads the register defaults
// the result strobe cannot be stalled by the receiver
`timescale 1ns / 1ps
module uv_sphere_vertex_generator #(
    parameter int ANGLE_ITERATIONS = 16,
    parameter int INDEX_BITS       = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  uvs_pkg::t_vtx_req i_req,
    output logic              o_strobe,
    output uvs_pkg::t_vtx_res o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import uvs_pkg::*;

    localparam int IB    = INDEX_BITS;
    localparam int NUM_W = IB + 34;
    localparam int DEN_W = IB + 1;
    localparam int ITERS = (ANGLE_ITERATIONS > MAX_ITER) ? MAX_ITER : ANGLE_ITERATIONS;

    // configuration registers
    logic [14:0] r_radius;
    logic [7:0]  r_slices;
    logic [7:0]  r_stacks;
    logic        n_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 15'd256;
            r_slices <= 8'd16;
            r_stacks <= 8'd16;
        end else if (n_wr && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                REG_RADIUS: r_radius <= pwdata[14:0];
                REG_SLICES: r_slices <= pwdata[7:0];
                REG_STACKS: r_stacks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {17'd0, r_radius};
            REG_SLICES: prdata = {24'd0, r_slices};
            REG_STACKS: prdata = {24'd0, r_stacks};
            default:    prdata = '0;
        endcase
    end

    // request decode
    logic [IB-1:0] n_stk;
    logic [IB-1:0] n_slc;
    logic [IB-1:0] n_stks;
    logic [IB-1:0] n_slcs;
    t_vtx_ctl      n_ctl;

    always_comb begin
        n_stk  = IB'(i_req.stack_index);
        n_slc  = IB'(i_req.slice_index);
        n_stks = IB'(r_stacks);
        n_slcs = IB'(r_slices);
        n_ctl.bad    = (n_slcs < IB'(3)) || (n_stks < IB'(2)) ||
                       (n_stk > n_stks) || (n_slc > n_slcs);
        n_ctl.top    = n_stk == '0;
        n_ctl.bottom = n_stk == n_stks;
        n_ctl.radius = r_radius;
        n_ctl.tex_u  = '0;
        n_ctl.tex_v  = '0;
    end

    // rounded quotients: phi = floor((k*2^32+n)/(2n)), theta = floor((k*2^33+n)/(2n)),
    // tex = floor((k*2^16+n)/(2n)); all dividers share one latency
    localparam int TAG_W = $bits(t_vtx_ctl) + 2 * IB;
    t_vtx_ctl              w_ctl;
    logic                  w_dvx_p, w_dvx_t, w_dvu, w_dvv;
    logic [NUM_W-1:0]      w_qx_p, w_qx_t;
    logic [IB+17:0]        w_qu, w_qv;
    logic [TAG_W-1:0]      w_tx_p, w_tx_t;
    logic [0:0]            w_tu, w_tv;
    logic [NUM_W-IB-19:0]  w_qx_unused_u, w_qx_unused_v;

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_phi2 (
        .i_clk, .i_rst_n,
        .i_valid (start),
        .i_num   (NUM_W'({n_stk, 32'd0}) + NUM_W'(n_stks)),
        .i_den   ({n_stks, 1'b0}),
        .i_tag   ({n_ctl, n_stk, n_slc}),
        .o_valid (w_dvx_p),
        .o_quo   (w_qx_p),
        .o_tag   (w_tx_p)
    );

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div_theta2 (
        .i_clk, .i_rst_n,
        .i_valid (start),
        .i_num   (NUM_W'({n_slc, 33'd0}) + NUM_W'(n_slcs)),
        .i_den   ({n_slcs, 1'b0}),
        .i_tag   ({n_ctl, n_stk, n_slc}),
        .o_valid (w_dvx_t),
        .o_quo   (w_qx_t),
        .o_tag   (w_tx_t)
    );

    // texture dividers padded to the same latency as the angle dividers
    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(1)) u_div_u (
        .i_clk, .i_rst_n,
        .i_valid (start),
        .i_num   (NUM_W'({n_slc, 16'd0}) + NUM_W'(n_slcs)),
        .i_den   ({n_slcs, 1'b0}),
        .i_tag   (1'b0),
        .o_valid (w_dvu),
        .o_quo   ({w_qx_unused_u, w_qu}),
        .o_tag   (w_tu)
    );

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(1)) u_div_v (
        .i_clk, .i_rst_n,
        .i_valid (start),
        .i_num   (NUM_W'({n_stk, 16'd0}) + NUM_W'(n_stks)),
        .i_den   ({n_stks, 1'b0}),
        .i_tag   (1'b0),
        .o_valid (w_dvv),
        .o_quo   ({w_qx_unused_v, w_qv}),
        .o_tag   (w_tv)
    );

    // collect divider outputs
    logic     r_da;
    t_vtx_ctl r_dctl;
    logic [ANG_W-1:0] r_phi, r_theta;

    always_comb begin
        w_ctl       = w_tx_p[TAG_W-1 -: $bits(t_vtx_ctl)];
        w_ctl.tex_u = w_qu[15:0];
        w_ctl.tex_v = w_qv[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_da <= 1'b0;
        else          r_da <= w_dvx_p;
        r_dctl  <= w_ctl;
        r_phi   <= w_qx_p[ANG_W-1:0];
        r_theta <= w_qx_t[ANG_W-1:0];
    end

    // sine and cosine of both angles
    logic                     w_cv_p, w_cv_t;
    logic signed [CORD_W-1:0] w_cp, w_sp, w_ct, w_st;
    t_vtx_ctl                 r_cctl [ITERS+1];

    uvs_cordic #(.ITERS(ITERS)) u_cordic_phi (
        .i_clk, .i_rst_n, .i_valid(r_da), .i_ang(r_phi),
        .o_valid(w_cv_p), .o_cos(w_cp), .o_sin(w_sp)
    );

    uvs_cordic #(.ITERS(ITERS)) u_cordic_theta (
        .i_clk, .i_rst_n, .i_valid(r_da), .i_ang(r_theta),
        .o_valid(w_cv_t), .o_cos(w_ct), .o_sin(w_st)
    );

    // control rides beside the cordic
    assign r_cctl[0] = r_dctl;
    for (genvar s = 0; s < ITERS; s++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            r_cctl[s+1] <= r_cctl[s];
        end
    end

    uvs_shade u_shade (
        .i_clk, .i_rst_n,
        .i_valid (w_cv_p),
        .i_ctl   (r_cctl[ITERS]),
        .i_cp    (w_cp),
        .i_sp    (w_sp),
        .i_ct    (w_ct),
        .i_st    (w_st),
        .o_valid (o_strobe),
        .o_res   (o_res)
    );

    // unused tags and quotient bits
    logic w_unused;
    assign w_unused = ^{w_tx_p[2*IB-1:0], w_tu, w_tv, w_tx_t, w_qx_unused_u,
                        w_qx_unused_v, w_qu[IB+17:16], w_qv[IB+17:16],
                        w_qx_p[NUM_W-1:ANG_W], w_qx_t[NUM_W-1:ANG_W], pwdata[31:15]};

    // twin pipelines stay in lockstep
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_cv_p == w_cv_t)
        else $error("cordic valid mismatch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dvx_t == w_dvx_p && w_dvu == w_dvv && w_dvu == w_dvx_p)
        else $error("divider valid mismatch");
    // an error result carries no geometry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.bad_index |-> o_res.pos_y == 16'sd0 && o_res.tex_v == 16'd0)
        else $error("error result not zeroed");
endmodule

// ===== tb/sv/uv_sphere_vertex_generator_test.sv =====
// testbench for the uv sphere vertex generator: directed table, random vertices, bit-exact predictor
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_test;
    import uvs_pkg::*;

    localparam int ITERS = 16;
    localparam int LATENCY = 1 + (8 + 34) + ITERS + 4;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_vtx_req    i_req = '0;
    logic        o_strobe;
    t_vtx_res    o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    uv_sphere_vertex_generator #(.ANGLE_ITERATIONS(ITERS), .INDEX_BITS(8)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_strobe(o_strobe), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the configuration
    logic [14:0] cfg_radius;
    logic [7:0]  cfg_slices;
    logic [7:0]  cfg_stacks;

    t_vtx_res  pending_vertices[$];
    int        mismatch_count = 0;
    int        vertex_count = 0;
    longint    cycle_count = 0;
    int        idle_pct = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // rotation-mode cordic on a binary-turn angle, outputs in q1.30
    task automatic cordic_sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint x, y, z, dx, dy;
        logic [31:0] a;
        a = ang;
        flip = a[31] ^ a[30];
        if (flip) a = a - 32'h80000000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    // expected vertex for one request under the current configuration
    task automatic predict_vertex(input t_vtx_req rq, output t_vtx_res rs);
        longint stk, slc, stacks, slices, r, cp, sp, ct, st, px, pz;
        logic [31:0] phi, theta;
        stk = rq.stack_index; slc = rq.slice_index;
        stacks = cfg_stacks; slices = cfg_slices; r = cfg_radius;
        rs = '0;
        if (slices < 3 || stacks < 2 || stk > stacks || slc > slices) begin
            rs.bad_index = 1'b1;
        end else if (stk == 0 || stk == stacks) begin
            rs.pos_y  = (stk == 0) ? 16'(r) : 16'(-r);
            rs.norm_y = (stk == 0) ? 16'sd16384 : -16'sd16384;
            rs.tan_x  = 16'sd256;
            rs.tex_v  = (stk == 0) ? 16'd0 : 16'd32768;
        end else begin
            phi   = 32'(((stk << 32) + stacks) / (2 * stacks));
            theta = 32'(((slc << 33) + slices) / (2 * slices));
            cordic_sin_cos(phi, cp, sp);
            cordic_sin_cos(theta, ct, st);
            px = round_half_up(round_half_up(sp * ct, 30) * r, 30);
            pz = round_half_up(round_half_up(sp * st, 30) * r, 30);
            rs.pos_x  = 16'(sat(px, -32768, 32767));
            rs.pos_y  = 16'(sat(round_half_up(cp * r, 30), -32768, 32767));
            rs.pos_z  = 16'(sat(pz, -32768, 32767));
            rs.norm_x = 16'(sat(round_half_up(sp * ct, 46), -16384, 16384));
            rs.norm_y = 16'(sat(round_half_up(cp * 65536, 32), -16384, 16384));
            rs.norm_z = 16'(sat(round_half_up(sp * st, 46), -16384, 16384));
            rs.tan_x  = 16'(sat(-pz, -32768, 32767));
            rs.tan_z  = 16'(sat(px, -32768, 32767));
            rs.tex_u  = 16'((slc * 65536 + slices) / (2 * slices));
            rs.tex_v  = 16'((stk * 65536 + stacks) / (2 * stacks));
        end
    endtask

    // compare each strobed vertex with the oldest expectation
    always @(posedge i_clk) begin
        t_vtx_res want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (pending_vertices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected vertex %h", o_res);
            end else begin
                want = pending_vertices.pop_front();
                if (want !== o_res) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("vertex mismatch: expected %p actual %p", want, o_res);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // apb register write, setup then access, then read back
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] exp_rd;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RADIUS: begin
                cfg_radius = value[14:0];
                exp_rd = {17'd0, value[14:0]};
            end
            REG_SLICES: begin
                cfg_slices = value[7:0];
                exp_rd = {24'd0, value[7:0]};
            end
            REG_STACKS: begin
                cfg_stacks = value[7:0];
                exp_rd = {24'd0, value[7:0]};
            end
            default: exp_rd = '0;
        endcase
        @(posedge i_clk);
        if (prdata !== exp_rd) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("register read mismatch: expected %h actual %h", exp_rd, prdata);
        end
    endtask

    // wait until every vertex has come back, then let the pipeline drain
    task automatic drain();
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(input int rad, input int slices, input int stacks);
        drain();
        reg_write(REG_RADIUS, 32'(rad));
        reg_write(REG_SLICES, 32'(slices));
        reg_write(REG_STACKS, 32'(stacks));
    endtask

    // one vertex transfer, with optional idle cycles before it
    task automatic send_vertex(input t_vtx_req rq, input logic check_fixed,
                               input t_vtx_res fixed);
        t_vtx_res want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_vertex(rq, want);
        if (check_fixed && want !== fixed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row %p: expected %p predicted %p", rq, fixed, want);
        end
        if (check_fixed) want = fixed;
        pending_vertices = {pending_vertices, want};
        vertex_count++;
    endtask

    // random request biased toward the valid index range
    function automatic t_vtx_req random_vertex();
        t_vtx_req rq;
        if ($urandom_range(9) < 8) begin
            rq.stack_index = 8'($urandom_range(int'(cfg_stacks)));
            rq.slice_index = 8'($urandom_range(int'(cfg_slices)));
        end else begin
            rq.stack_index = 8'($urandom);
            rq.slice_index = 8'($urandom);
        end
        return rq;
    endfunction

    typedef struct {
        t_vtx_req   rq;
        logic       fixed;
        t_vtx_res   want;
    } t_table_row;

    t_table_row directed_rows[$];

    function automatic t_vtx_res pole_result(input logic bottom, input int rad);
        t_vtx_res rs;
        rs = '0;
        rs.pos_y  = bottom ? 16'(-rad) : 16'(rad);
        rs.norm_y = bottom ? -16'sd16384 : 16'sd16384;
        rs.tan_x  = 16'sd256;
        rs.tex_v  = bottom ? 16'd32768 : 16'd0;
        return rs;
    endfunction

    initial begin
        t_vtx_res bad;
        int phase_rad[4];
        int phase_sl[4];
        int phase_st[4];
        int phase_idle[4];
        bad = '0;
        bad.bad_index = 1'b1;
        cfg_radius = 15'd256; cfg_slices = 8'd16; cfg_stacks = 8'd16;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset configuration
        directed_rows = '{
            '{'{8'd0, 8'd0}, 1'b1, pole_result(1'b0, 256)},
            '{'{8'd16, 8'd5}, 1'b1, pole_result(1'b1, 256)},
            '{'{8'd17, 8'd0}, 1'b1, bad},
            '{'{8'd0, 8'd17}, 1'b1, bad},
            '{'{8'd255, 8'd255}, 1'b1, bad},
            '{'{8'd8, 8'd0}, 1'b0, bad},
            '{'{8'd8, 8'd16}, 1'b0, bad},
            '{'{8'd1, 8'd4}, 1'b0, bad},
            '{'{8'd15, 8'd12}, 1'b0, bad},
            '{'{8'd4, 8'd8}, 1'b0, bad},
            '{'{8'd8, 8'd170}, 1'b1, bad},
            '{'{8'd170, 8'd1}, 1'b1, bad}
        };
        foreach (directed_rows[k])
            send_vertex(directed_rows[k].rq, directed_rows[k].fixed, directed_rows[k].want);

        // extremes of the configuration
        configure(32767, 255, 255);
        send_vertex('{8'd127, 8'd0}, 1'b0, bad);
        send_vertex('{8'd1, 8'd200}, 1'b0, bad);
        send_vertex('{8'd255, 8'd255}, 1'b1, pole_result(1'b1, 32767));
        configure(0, 3, 2);
        send_vertex('{8'd1, 8'd3}, 1'b0, bad);
        send_vertex('{8'd1, 8'd2}, 1'b0, bad);
        configure(1, 2, 16);
        send_vertex('{8'd1, 8'd1}, 1'b1, bad);
        configure(300, 16, 1);
        send_vertex('{8'd0, 8'd0}, 1'b1, bad);

        // random phases across settings and idling patterns
        phase_rad  = '{256, 32767, 1, 5000};
        phase_sl   = '{16, 255, 3, 7};
        phase_st   = '{16, 255, 2, 9};
        phase_idle = '{0, 51, 0, 17};
        for (int p = 0; p < 4; p++) begin
            configure(phase_rad[p], phase_sl[p], phase_st[p]);
            idle_pct = phase_idle[p];
            for (int n = 0; n < 150; n++) begin
                send_vertex(random_vertex(), 1'b0, bad);
                if (n == 75) drain();
            end
        end
        configure(int'($urandom_range(32767)), int'($urandom_range(3, 255)),
                  int'($urandom_range(2, 255)));
        idle_pct = 0;
        for (int n = 0; n < 40; n++) send_vertex(random_vertex(), 1'b0, bad);

        drain();
        $display("covered %0d vertex requests: poles, seam, bad indexes, count and radius extremes",
                 vertex_count);
        if (mismatch_count == 0 && pending_vertices.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/uvs_pkg.sv
rtl/core/uvs_div.sv
rtl/core/uvs_cordic.sv
rtl/core/uvs_shade.sv
rtl/core/uv_sphere_vertex_generator.sv
tb/sv/uv_sphere_vertex_generator_test.sv
